[design/sse_pkg.sv]
// Shared types and constants for the sample statistics engine.
// No dependencies; used by sample_statistics_engine_unit.
package sse_pkg;

   localparam int DEFAULT_MAX_SAMPLES = 256;
   localparam int DIV_W = 128;

   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
   localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum logic [4:0] {
      S_IDLE,
      S_OP_DIV,
      S_INS_RD,
      S_INS_CMP,
      S_MEAN,
      S_MEAN_WAIT,
      S_MED0,
      S_MED1,
      S_MED2,
      S_VAR_RD,
      S_VAR_D,
      S_VAR_M0,
      S_VAR_M1,
      S_VAR_M2,
      S_VAR_M3,
      S_SQ,
      S_SQ_WAIT,
      S_SQRT,
      S_RSD,
      S_RSD_WAIT,
      S_OPT,
      S_OPT_WAIT,
      S_TPO,
      S_TPO_WAIT,
      S_OUT
   } state_type;

endpackage

[design/sample_statistics_engine_unit.sv]
// Sample statistics engine: per-operation time store, totals and final statistics.
// Depends on sse_pkg (state type, saturation constants, default depth).
//
// Usage: each request on req_* is one timing sample (Q32.16 time, iteration count,
// last mark). The block stores time/iterations in a sorted sample memory and keeps
// saturating totals. The request with req_last_sample produces one response on rsp_*
// with median, mean, population deviation, relative deviation, throughput, time per
// operation, totals, sample count, unit echo and an error flag; the set then clears.
// csr_time_unit is written through csr_valid/csr_ready (always ready); the user
// writes it only while idle, which the block does not enforce. One request is
// processed at a time; req_ready is high only while idle. Per sample: accept, the
// bit-serial divider (skipped for a zero iteration count), then an insertion pass
// that moves each stored entry larger than the new one up by one place and then
// places the new one (one memory read and one write per step). A last sample adds
// 64-bit and 128-bit restoring divisions on the shared divider, a 64-step square
// root and a per-sample variance pass through one 24x24 multiplier.
// Reset (synchronous) clears counts, totals, error and the unit register; the sample
// memory is not cleared since only entries written in the current set are read.
// When the receiver stalls, the response register holds; a following set runs up to
// its output step and waits there until the pending response is taken.
module sample_statistics_engine_unit #(
   parameter int MAX_SAMPLES = sse_pkg::DEFAULT_MAX_SAMPLES,
   localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
   localparam int CW = $clog2(MAX_SAMPLES + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [47:0]   req_sample_time,
   input  logic [31:0]   req_sample_iterations,
   input  logic          req_last_sample,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [47:0]   rsp_median_time,
   output logic [47:0]   rsp_mean_time,
   output logic [47:0]   rsp_std_deviation,
   output logic [31:0]   rsp_relative_deviation,
   output logic [47:0]   rsp_ops_per_time,
   output logic [47:0]   rsp_time_per_operation,
   output logic [63:0]   rsp_iterations_total,
   output logic [63:0]   rsp_time_total,
   output logic [CW-1:0] rsp_samples_used,
   output logic [1:0]    rsp_unit_echo,
   output logic          rsp_error_flag,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_time_unit
);

   localparam int SUMW = 48 + CW;

   sse_pkg::state_type state_ff, state_in;

   logic [47:0]   mem [MAX_SAMPLES];
   logic [47:0]   mem_q_ff;
   logic          mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [47:0]   mem_wd;

   logic [CW-1:0]  count_ff, var_i_ff;
   logic [AW-1:0]  ins_j_ff;
   logic [63:0]    tacc_ff, iacc_ff;
   logic [SUMW-1:0] sum_ff;
   logic           err_ff, last_ff, rsp_valid_ff;
   logic [1:0]     unit_ff;
   logic [47:0]    v_ff, mean_ff, median_ff, med_a_ff, d_ff;
   logic [31:0]    rsd_ff;
   logic [47:0]    opt_ff, tpo_ff;
   logic [47:0]    prod_ff;
   logic [127:0]   sq_ff;

   logic [127:0]   div_num_ff;
   logic [63:0]    div_rem_ff, div_den_ff, div_rem_nx;
   logic [7:0]     div_cnt_ff;
   logic [64:0]    div_sh;
   logic           div_ge;

   logic [127:0]   rad_ff;
   logic [66:0]    rt_rem_ff, rt_rem2, rt_trial;
   logic [63:0]    rt_res_ff;
   logic [6:0]     rt_cnt_ff;
   logic           rt_ge;

   logic [23:0]    mul_a, mul_b;
   logic [47:0]    mul_p;
   logic [64:0]    tacc_sum, iacc_sum;
   logic [CW-1:0]  half;
   logic           n_even, ins_move, ins_stop;
   logic [71:0]    rsd_num;

   assign half     = count_ff >> 1;
   assign n_even   = ~count_ff[0];
   assign ins_move = mem_q_ff > v_ff;
   assign ins_stop = last_ff;
   assign tacc_sum = {1'b0, tacc_ff} + 65'(req_sample_time);
   assign iacc_sum = {1'b0, iacc_ff} + 65'(req_sample_iterations);
   assign rsd_num  = (72'(rt_res_ff[47:0]) << 22) + (72'(rt_res_ff[47:0]) << 21)
                   + (72'(rt_res_ff[47:0]) << 18);

   assign div_sh     = {div_rem_ff, div_num_ff[127]};
   assign div_ge     = div_sh >= {1'b0, div_den_ff};
   assign div_rem_nx = div_ge ? 64'(div_sh - {1'b0, div_den_ff}) : div_sh[63:0];

   assign rt_rem2  = {rt_rem_ff[64:0], rad_ff[127:126]};
   assign rt_trial = {1'b0, rt_res_ff, 2'b01};
   assign rt_ge    = rt_rem2 >= rt_trial;

   assign mul_a = (state_ff == sse_pkg::S_VAR_M2) ? d_ff[47:24] : d_ff[23:0];
   assign mul_b = (state_ff == sse_pkg::S_VAR_M0) ? d_ff[23:0] : d_ff[47:24];
   assign mul_p = {24'd0, mul_a} * {24'd0, mul_b};

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sse_pkg::S_IDLE: begin
            if (req_valid) begin
               if (count_ff < CW'(MAX_SAMPLES)) begin
                  state_in = (req_sample_iterations == 32'd0) ? sse_pkg::S_INS_RD
                                                             : sse_pkg::S_OP_DIV;
               end else begin
                  state_in = req_last_sample ? sse_pkg::S_MEAN : sse_pkg::S_IDLE;
               end
            end
         end
         sse_pkg::S_OP_DIV:
            if (div_cnt_ff == 8'd0) state_in = sse_pkg::S_INS_RD;
         sse_pkg::S_INS_RD:
            if (ins_j_ff == '0) begin
               state_in = ins_stop ? sse_pkg::S_MEAN : sse_pkg::S_IDLE;
            end else begin
               state_in = sse_pkg::S_INS_CMP;
            end
         sse_pkg::S_INS_CMP:
            if (ins_move) begin
               state_in = sse_pkg::S_INS_RD;
            end else begin
               state_in = ins_stop ? sse_pkg::S_MEAN : sse_pkg::S_IDLE;
            end
         sse_pkg::S_MEAN:      state_in = sse_pkg::S_MEAN_WAIT;
         sse_pkg::S_MEAN_WAIT:
            if (div_cnt_ff == 8'd0) state_in = sse_pkg::S_MED0;
         sse_pkg::S_MED0:      state_in = sse_pkg::S_MED1;
         sse_pkg::S_MED1:      state_in = sse_pkg::S_MED2;
         sse_pkg::S_MED2:      state_in = sse_pkg::S_VAR_RD;
         sse_pkg::S_VAR_RD:    state_in = sse_pkg::S_VAR_D;
         sse_pkg::S_VAR_D:     state_in = sse_pkg::S_VAR_M0;
         sse_pkg::S_VAR_M0:    state_in = sse_pkg::S_VAR_M1;
         sse_pkg::S_VAR_M1:    state_in = sse_pkg::S_VAR_M2;
         sse_pkg::S_VAR_M2:    state_in = sse_pkg::S_VAR_M3;
         sse_pkg::S_VAR_M3:
            state_in = (var_i_ff + CW'(1) == count_ff) ? sse_pkg::S_SQ : sse_pkg::S_VAR_RD;
         sse_pkg::S_SQ:        state_in = sse_pkg::S_SQ_WAIT;
         sse_pkg::S_SQ_WAIT:
            if (div_cnt_ff == 8'd0) state_in = sse_pkg::S_SQRT;
         sse_pkg::S_SQRT:
            if (rt_cnt_ff == 7'd0) state_in = sse_pkg::S_RSD;
         sse_pkg::S_RSD:
            state_in = (mean_ff == 48'd0) ? sse_pkg::S_OPT : sse_pkg::S_RSD_WAIT;
         sse_pkg::S_RSD_WAIT:
            if (div_cnt_ff == 8'd0) state_in = sse_pkg::S_OPT;
         sse_pkg::S_OPT:
            state_in = (tacc_ff == 64'd0) ? sse_pkg::S_TPO : sse_pkg::S_OPT_WAIT;
         sse_pkg::S_OPT_WAIT:
            if (div_cnt_ff == 8'd0) state_in = sse_pkg::S_TPO;
         sse_pkg::S_TPO:
            state_in = (iacc_ff == 64'd0) ? sse_pkg::S_OUT : sse_pkg::S_TPO_WAIT;
         sse_pkg::S_TPO_WAIT:
            if (div_cnt_ff == 8'd0) state_in = sse_pkg::S_OUT;
         sse_pkg::S_OUT:
            if (!rsp_valid_ff || rsp_ready) state_in = sse_pkg::S_IDLE;
         default: state_in = sse_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      mem_wa    = ins_j_ff;
      mem_wd    = v_ff;
      mem_ra    = var_i_ff[AW-1:0];
      unique case (state_ff)
         sse_pkg::S_IDLE: req_ready = 1'b1;
         sse_pkg::S_INS_RD: begin
            mem_ra = ins_j_ff - AW'(1);
            mem_we = (ins_j_ff == '0);
         end
         sse_pkg::S_INS_CMP: begin
            mem_we = 1'b1;
            mem_wd = ins_move ? mem_q_ff : v_ff;
         end
         sse_pkg::S_MED0: mem_ra = half[AW-1:0];
         sse_pkg::S_MED1: mem_ra = half[AW-1:0] - AW'(1);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_q_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sse_pkg::S_IDLE;
         count_ff     <= '0;
         tacc_ff      <= '0;
         iacc_ff      <= '0;
         sum_ff       <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         unit_ff      <= 2'd0;
         div_cnt_ff   <= 8'd0;
         rt_cnt_ff    <= 7'd0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) unit_ff <= csr_time_unit;
         if (rsp_valid_ff && rsp_ready && state_ff != sse_pkg::S_OUT) rsp_valid_ff <= 1'b0;

         if (div_cnt_ff != 8'd0) begin
            div_rem_ff <= div_rem_nx;
            div_num_ff <= {div_num_ff[126:0], div_ge};
            div_cnt_ff <= div_cnt_ff - 8'd1;
         end

         unique case (state_ff)
            sse_pkg::S_IDLE:
               if (req_valid) begin
                  last_ff <= req_last_sample;
                  if (count_ff < CW'(MAX_SAMPLES)) begin
                     count_ff <= count_ff + CW'(1);
                     ins_j_ff <= count_ff[AW-1:0];
                     tacc_ff  <= tacc_sum[64] ? sse_pkg::MAX64 : tacc_sum[63:0];
                     iacc_ff  <= iacc_sum[64] ? sse_pkg::MAX64 : iacc_sum[63:0];
                     if (tacc_sum[64] || iacc_sum[64] || req_sample_iterations == 32'd0)
                        err_ff <= 1'b1;
                     if (req_sample_iterations == 32'd0) begin
                        v_ff   <= sse_pkg::MAX48;
                        sum_ff <= sum_ff + SUMW'(sse_pkg::MAX48);
                     end else begin
                        div_num_ff <= {req_sample_time, 80'd0};
                        div_den_ff <= 64'(req_sample_iterations);
                        div_rem_ff <= 64'd0;
                        div_cnt_ff <= 8'd48;
                     end
                  end else begin
                     err_ff <= 1'b1;
                  end
               end
            sse_pkg::S_OP_DIV:
               if (div_cnt_ff == 8'd0) begin
                  v_ff   <= div_num_ff[47:0];
                  sum_ff <= sum_ff + SUMW'(div_num_ff[47:0]);
               end
            sse_pkg::S_INS_CMP:
               if (ins_move) ins_j_ff <= ins_j_ff - AW'(1);
            sse_pkg::S_MEAN: begin
               div_num_ff <= {64'(sum_ff), 64'd0};
               div_den_ff <= 64'(count_ff);
               div_rem_ff <= 64'd0;
               div_cnt_ff <= 8'd64;
               sq_ff      <= 128'd0;
               var_i_ff   <= '0;
            end
            sse_pkg::S_MEAN_WAIT:
               if (div_cnt_ff == 8'd0) mean_ff <= div_num_ff[47:0];
            sse_pkg::S_MED1: med_a_ff <= mem_q_ff;
            sse_pkg::S_MED2:
               median_ff <= n_even ? 48'(({1'b0, med_a_ff} + {1'b0, mem_q_ff}) >> 1)
                                   : med_a_ff;
            sse_pkg::S_VAR_D:
               d_ff <= (mem_q_ff >= mean_ff) ? mem_q_ff - mean_ff : mean_ff - mem_q_ff;
            sse_pkg::S_VAR_M0: prod_ff <= mul_p;
            sse_pkg::S_VAR_M1: begin
               sq_ff   <= sq_ff + 128'(prod_ff);
               prod_ff <= mul_p;
            end
            sse_pkg::S_VAR_M2: begin
               sq_ff   <= sq_ff + (128'(prod_ff) << 25);
               prod_ff <= mul_p;
            end
            sse_pkg::S_VAR_M3: begin
               sq_ff    <= sq_ff + (128'(prod_ff) << 48);
               var_i_ff <= var_i_ff + CW'(1);
            end
            sse_pkg::S_SQ: begin
               div_num_ff <= sq_ff;
               div_den_ff <= 64'(count_ff);
               div_rem_ff <= 64'd0;
               div_cnt_ff <= 8'(sse_pkg::DIV_W);
            end
            sse_pkg::S_SQ_WAIT:
               if (div_cnt_ff == 8'd0) begin
                  rad_ff    <= div_num_ff;
                  rt_rem_ff <= 67'd0;
                  rt_res_ff <= 64'd0;
                  rt_cnt_ff <= 7'd64;
               end
            sse_pkg::S_SQRT:
               if (rt_cnt_ff != 7'd0) begin
                  rad_ff    <= {rad_ff[125:0], 2'b00};
                  rt_rem_ff <= rt_ge ? rt_rem2 - rt_trial : rt_rem2;
                  rt_res_ff <= {rt_res_ff[62:0], rt_ge};
                  rt_cnt_ff <= rt_cnt_ff - 7'd1;
               end
            sse_pkg::S_RSD:
               if (mean_ff == 48'd0) begin
                  rsd_ff <= sse_pkg::MAX32;
                  err_ff <= 1'b1;
               end else begin
                  div_num_ff <= 128'(rsd_num);
                  div_den_ff <= 64'(mean_ff);
                  div_rem_ff <= 64'd0;
                  div_cnt_ff <= 8'(sse_pkg::DIV_W);
               end
            sse_pkg::S_RSD_WAIT:
               if (div_cnt_ff == 8'd0) begin
                  if (div_num_ff[127:32] != '0) begin
                     rsd_ff <= sse_pkg::MAX32;
                     err_ff <= 1'b1;
                  end else begin
                     rsd_ff <= div_num_ff[31:0];
                  end
               end
            sse_pkg::S_OPT:
               if (tacc_ff == 64'd0) begin
                  opt_ff <= sse_pkg::MAX48;
                  err_ff <= 1'b1;
               end else begin
                  div_num_ff <= {32'd0, iacc_ff, 32'd0};
                  div_den_ff <= tacc_ff;
                  div_rem_ff <= 64'd0;
                  div_cnt_ff <= 8'(sse_pkg::DIV_W);
               end
            sse_pkg::S_OPT_WAIT:
               if (div_cnt_ff == 8'd0) begin
                  if (div_num_ff[127:48] != '0) begin
                     opt_ff <= sse_pkg::MAX48;
                     err_ff <= 1'b1;
                  end else begin
                     opt_ff <= div_num_ff[47:0];
                  end
               end
            sse_pkg::S_TPO:
               if (iacc_ff == 64'd0) begin
                  tpo_ff <= sse_pkg::MAX48;
                  err_ff <= 1'b1;
               end else begin
                  div_num_ff <= {tacc_ff, 64'd0};
                  div_den_ff <= iacc_ff;
                  div_rem_ff <= 64'd0;
                  div_cnt_ff <= 8'd64;
               end
            sse_pkg::S_TPO_WAIT:
               if (div_cnt_ff == 8'd0) begin
                  if (div_num_ff[63:48] != '0) begin
                     tpo_ff <= sse_pkg::MAX48;
                     err_ff <= 1'b1;
                  end else begin
                     tpo_ff <= div_num_ff[47:0];
                  end
               end
            sse_pkg::S_OUT:
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  count_ff     <= '0;
                  tacc_ff      <= '0;
                  iacc_ff      <= '0;
                  sum_ff       <= '0;
                  err_ff       <= 1'b0;
               end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == sse_pkg::S_OUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_median_time        <= median_ff;
         rsp_mean_time          <= mean_ff;
         rsp_std_deviation      <= rt_res_ff[47:0];
         rsp_relative_deviation <= rsd_ff;
         rsp_ops_per_time       <= opt_ff;
         rsp_time_per_operation <= tpo_ff;
         rsp_iterations_total   <= iacc_ff;
         rsp_time_total         <= tacc_ff;
         rsp_samples_used       <= count_ff;
         rsp_unit_echo          <= unit_ff;
         rsp_error_flag         <= err_ff;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SAMPLES))
      else $error("sample count beyond capacity");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sse_pkg::S_OUT) |-> (div_cnt_ff == 8'd0 && rt_cnt_ff == 7'd0))
      else $error("response issued while arithmetic busy");

   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (CW'(mem_wa) < count_ff))
      else $error("sample write outside stored range");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready && state_ff != sse_pkg::S_OUT) |=> !rsp_valid_ff)
      else $error("response repeated after acceptance");

endmodule

[bench/sample_statistics_engine_unit_tb.sv]
// Self-checking testbench for sample_statistics_engine_unit: sends timing-sample
// requests, predicts each set's statistics and checks every response field.
// Depends on sse_pkg and sample_statistics_engine_unit.
module sample_statistics_engine_unit_tb;

   localparam int DEPTH = sse_pkg::DEFAULT_MAX_SAMPLES;
   localparam int IDLE_LIMIT = 40000;

   typedef struct {
      logic [47:0] median_time;
      logic [47:0] mean_time;
      logic [47:0] std_deviation;
      logic [31:0] relative_deviation;
      logic [47:0] ops_per_time;
      logic [47:0] time_per_operation;
      logic [63:0] iterations_total;
      logic [63:0] time_total;
      logic [8:0]  samples_used;
      logic [1:0]  unit_echo;
      logic        error_flag;
   } stats_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [47:0] req_sample_time = '0;
   logic [31:0] req_sample_iterations = '0;
   logic        req_last_sample = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [47:0] rsp_median_time, rsp_mean_time, rsp_std_deviation;
   logic [31:0] rsp_relative_deviation;
   logic [47:0] rsp_ops_per_time, rsp_time_per_operation;
   logic [63:0] rsp_iterations_total, rsp_time_total;
   logic [8:0]  rsp_samples_used;
   logic [1:0]  rsp_unit_echo;
   logic        rsp_error_flag;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_time_unit = '0;

   logic [47:0] sorted_times[$];
   logic [63:0] time_sum;
   logic [63:0] iter_sum;
   logic        set_error;
   logic [1:0]  unit_reg;
   stats_type   pending_stats[$];

   int failures = 0;
   int items_sent = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   int stall_run = 0;
   int stall_mode = 0;

   sample_statistics_engine_unit dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [63:0] isqrt(logic [127:0] v);
      logic [63:0]  r;
      logic [127:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = {64'd0, r | (64'd1 << b)};
         if (c * c <= v) r = c[63:0];
      end
      return r;
   endfunction

   task automatic clear_set();
      sorted_times.delete();
      time_sum = '0;
      iter_sum = '0;
      set_error = 1'b0;
   endtask

   task automatic accumulate_sample(logic [47:0] t, logic [31:0] it, logic last);
      logic [47:0]  per_op;
      logic [64:0]  wide_sum;
      int           pos;
      int           n;
      logic [63:0]  mean_sum;
      logic [127:0] sq, q;
      logic [47:0]  d;
      stats_type    s;
      if (sorted_times.size() < DEPTH) begin
         if (it == 0) begin
            per_op = sse_pkg::MAX48;
            set_error = 1'b1;
         end else begin
            per_op = t / 48'(it);
         end
         pos = 0;
         while (pos < sorted_times.size() && sorted_times[pos] <= per_op) pos++;
         sorted_times.insert(pos, per_op);
         wide_sum = {1'b0, time_sum} + 65'(t);
         if (wide_sum[64]) begin
            time_sum = sse_pkg::MAX64;
            set_error = 1'b1;
         end else time_sum = wide_sum[63:0];
         wide_sum = {1'b0, iter_sum} + 65'(it);
         if (wide_sum[64]) begin
            iter_sum = sse_pkg::MAX64;
            set_error = 1'b1;
         end else iter_sum = wide_sum[63:0];
      end else begin
         set_error = 1'b1;
      end
      if (!last) return;

      n = sorted_times.size();
      s.error_flag = set_error;
      if (n % 2 == 0)
         s.median_time = 48'(({1'b0, sorted_times[n/2-1]} + {1'b0, sorted_times[n/2]}) >> 1);
      else
         s.median_time = sorted_times[n/2];
      mean_sum = '0;
      foreach (sorted_times[i]) mean_sum += 64'(sorted_times[i]);
      s.mean_time = 48'(mean_sum / 64'(n));
      sq = '0;
      foreach (sorted_times[i]) begin
         d = (sorted_times[i] >= s.mean_time) ? sorted_times[i] - s.mean_time
                                              : s.mean_time - sorted_times[i];
         sq += {80'd0, d} * {80'd0, d};
      end
      s.std_deviation = 48'(isqrt(sq / 128'(n)));
      if (s.mean_time == 0) begin
         s.relative_deviation = sse_pkg::MAX32;
         s.error_flag = 1'b1;
      end else begin
         q = ({80'd0, s.std_deviation} * 128'd6553600) / 128'(s.mean_time);
         if (q > 128'(sse_pkg::MAX32)) begin
            s.relative_deviation = sse_pkg::MAX32;
            s.error_flag = 1'b1;
         end else s.relative_deviation = q[31:0];
      end
      if (time_sum == 0) begin
         s.ops_per_time = sse_pkg::MAX48;
         s.error_flag = 1'b1;
      end else begin
         q = {32'd0, iter_sum, 32'd0} / 128'(time_sum);
         if (q > 128'(sse_pkg::MAX48)) begin
            s.ops_per_time = sse_pkg::MAX48;
            s.error_flag = 1'b1;
         end else s.ops_per_time = q[47:0];
      end
      if (iter_sum == 0) begin
         s.time_per_operation = sse_pkg::MAX48;
         s.error_flag = 1'b1;
      end else begin
         q = 128'(time_sum / iter_sum);
         if (q > 128'(sse_pkg::MAX48)) begin
            s.time_per_operation = sse_pkg::MAX48;
            s.error_flag = 1'b1;
         end else s.time_per_operation = q[47:0];
      end
      s.iterations_total = iter_sum;
      s.time_total = time_sum;
      s.samples_used = n[8:0];
      s.unit_echo = unit_reg;
      pending_stats = {pending_stats, s};
      clear_set();
   endtask

   task automatic send_sample(logic [47:0] t, logic [31:0] it, logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock) req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_sample_time <= t;
      req_sample_iterations <= it;
      req_last_sample <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      accumulate_sample(t, it, last);
      items_sent++;
   endtask

   task automatic write_time_unit(logic [1:0] value);
      @(negedge clock) req_valid <= 1'b0;
      burst_left = 0;
      wait (pending_stats.size() == 0);
      repeat (100) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_time_unit <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      unit_reg = value;
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   function automatic logic [47:0] random_time();
      logic [47:0] v;
      v = 48'({$urandom, $urandom});
      return v >> $urandom_range(0, 47);
   endfunction

   function automatic logic [31:0] random_iterations();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return sse_pkg::MAX32;
         2, 3: return $urandom;
         default: return $urandom >> $urandom_range(8, 31);
      endcase
   endfunction

   task automatic test_directed();
      write_time_unit(2'd3);
      send_sample(sse_pkg::MAX48, 32'd1, 1'b1);
      send_sample(48'd0, 32'd1, 1'b1);
      send_sample(48'd12345, 32'd0, 1'b1);
      send_sample(48'd1, sse_pkg::MAX32, 1'b1);
      send_sample(sse_pkg::MAX48, sse_pkg::MAX32, 1'b1);
      send_sample(48'h0001_0000, 32'd1, 1'b0);
      send_sample(48'h0003_0000, 32'd1, 1'b1);
      send_sample(48'h0009_0000, 32'd3, 1'b0);
      send_sample(48'h0001_8000, 32'd2, 1'b0);
      send_sample(48'h0100_0000, 32'd7, 1'b1);
      send_sample(sse_pkg::MAX48, 32'd0, 1'b0);
      send_sample(sse_pkg::MAX48, 32'd1, 1'b1);
      send_sample(48'd1, sse_pkg::MAX32, 1'b0);
      send_sample(48'd1, sse_pkg::MAX32, 1'b1);
      send_sample(48'h5555_5555_5555, 32'hAAAA_AAAA, 1'b0);
      send_sample(48'hAAAA_AAAA_AAAA, 32'h5555_5555, 1'b1);
   endtask

   task automatic test_time_unit();
      for (int u = 0; u < 4; u++) begin
         write_time_unit(u[1:0]);
         send_sample(random_time(), random_iterations(), 1'b0);
         send_sample(random_time(), random_iterations(), 1'b1);
      end
   endtask

   task automatic test_buffer_full();
      write_time_unit(2'd1);
      for (int i = 0; i < DEPTH + 2; i++)
         send_sample(random_time(), 32'($urandom_range(1, 1000)), 1'b0);
      send_sample(random_time(), random_iterations(), 1'b1);
      for (int i = 0; i < DEPTH - 1; i++)
         send_sample(random_time(), random_iterations(), 1'b0);
      send_sample(random_time(), random_iterations(), 1'b1);
   endtask

   task automatic test_random_sets();
      int set_size;
      while (items_sent < 1950) begin
         if ($urandom_range(0, 9) == 0) write_time_unit(2'($urandom_range(0, 3)));
         set_size = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(1, 12);
         for (int i = 1; i <= set_size; i++)
            send_sample(random_time(), random_iterations(), i == set_size);
      end
      @(negedge clock) req_valid <= 1'b0;
   endtask

   task automatic check_field(string name, logic [63:0] expected, logic [63:0] actual);
      if (expected !== actual) begin
         $error("%s: expected %0h, got %0h", name, expected, actual);
         failures++;
      end
   endtask

   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_run = $urandom_range(1, 40);
      end
      stall_run--;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= 1'b0;
         default: rsp_ready <= ($urandom_range(0, 2) != 0);
      endcase
   end

   always @(posedge clock) begin
      stats_type s;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_stats.size() == 0) begin
            $error("response with no set pending");
            failures++;
         end else begin
            s = pending_stats.pop_front();
            check_field("median_time", 64'(s.median_time), 64'(rsp_median_time));
            check_field("mean_time", 64'(s.mean_time), 64'(rsp_mean_time));
            check_field("std_deviation", 64'(s.std_deviation), 64'(rsp_std_deviation));
            check_field("relative_deviation", 64'(s.relative_deviation),
                        64'(rsp_relative_deviation));
            check_field("ops_per_time", 64'(s.ops_per_time), 64'(rsp_ops_per_time));
            check_field("time_per_operation", 64'(s.time_per_operation),
                        64'(rsp_time_per_operation));
            check_field("iterations_total", s.iterations_total, rsp_iterations_total);
            check_field("time_total", s.time_total, rsp_time_total);
            check_field("samples_used", 64'(s.samples_used), 64'(rsp_samples_used));
            check_field("unit_echo", 64'(s.unit_echo), 64'(rsp_unit_echo));
            check_field("error_flag", 64'(s.error_flag), 64'(rsp_error_flag));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL sample_statistics_engine_unit");
         $finish;
      end
   end

   initial begin
      clear_set();
      unit_reg = '0;
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_directed();
      test_time_unit();
      test_buffer_full();
      test_random_sets();
      wait (pending_stats.size() == 0);
      repeat (200) @(posedge clock);
      if (failures == 0)
         $display("PASS sample_statistics_engine_unit");
      else
         $display("FAIL sample_statistics_engine_unit");
      $finish;
   end

endmodule
